// File: rtl/bced_pkg.sv
// Shared constants, codes and the queue entry type of the button click event detector.
package bced_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int BCED_QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LEVEL   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_TICKS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_TICKS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_MAX     = 3'd4;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_DOWN   = 3'd1;
    localparam logic [2:0] EV_UP     = 3'd2;
    localparam logic [2:0] EV_REPEAT = 3'd3;
    localparam logic [2:0] EV_SINGLE = 3'd4;
    localparam logic [2:0] EV_DOUBLE = 3'd5;
    localparam logic [2:0] EV_LSTART = 3'd6;
    localparam logic [2:0] EV_LHOLD  = 3'd7;

    localparam logic       ACTION_TICK = 1'b0;
    localparam logic [15:0] TIMER_MAX  = 16'hFFFF;

    typedef struct packed {
        logic       two;
        logic       pressed;
        logic [2:0] ev0;
        logic [2:0] lat0;
        logic [3:0] rep0;
        logic [2:0] ev1;
        logic [3:0] rep1;
    } bced_entry_t;

endpackage

// File: rtl/bced_in_if.sv
// Input channel carrying one sample tick or soft reset per transaction.
interface bced_in_if;
    logic valid;
    logic ready;
    logic action;
    logic raw_level;

    modport source (output valid, output action, output raw_level, input ready);
    modport sink (input valid, input action, input raw_level, output ready);
endinterface

// File: rtl/bced_out_if.sv
// Output channel carrying one click event result per transaction.
interface bced_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic       last;
    logic [2:0] latched_event;
    logic [3:0] repeat_count;
    logic       pressed;

    modport source (output valid, output event_res, output last, output latched_event,
                    output repeat_count, output pressed, input ready);
    modport sink (input valid, input event_res, input last, input latched_event,
                  input repeat_count, input pressed, output ready);
endinterface

// File: rtl/bced_front.sv
// Front part: configuration registers, debounce and click state machine per sample.
module bced_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    bced_in_if.sink                           sample,
    input  logic                              cfg_write_en,
    input  logic [bced_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bced_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push_ready,
    output logic                              push_valid,
    output bced_pkg::bced_entry_t             push_entry
);
    import bced_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRESS,
        ST_RELEASE,
        ST_REPEAT,
        ST_LONG
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] timer_reg, timer_next;
    logic [3:0]  debounce_reg, debounce_next;
    logic        stable_reg, stable_next;
    logic [3:0]  repeat_reg, repeat_next;
    logic [2:0]  held_reg, held_next;

    logic        active_reg;
    logic [3:0]  deb_ticks_reg;
    logic [15:0] short_reg;
    logic [15:0] long_reg;
    logic [3:0]  rmax_reg;

    logic        accept;
    logic        emitted;
    logic [2:0]  emit_ev;
    logic [15:0] timer_inc;
    logic [3:0]  dc_inc;
    logic        down;

    assign sample.ready = push_ready;
    assign push_valid   = sample.valid;
    assign accept       = sample.valid && push_ready;

    always_comb
    begin
        state_next    = state_reg;
        timer_next    = timer_reg;
        debounce_next = debounce_reg;
        stable_next   = stable_reg;
        repeat_next   = repeat_reg;
        held_next     = held_reg;
        emitted       = 1'b0;
        emit_ev       = EV_NONE;
        push_entry    = '0;
        timer_inc     = timer_reg;
        dc_inc        = debounce_reg + 4'd1;
        down          = 1'b0;

        if (sample.action != ACTION_TICK)
        begin
            state_next    = ST_IDLE;
            timer_next    = '0;
            repeat_next   = '0;
            held_next     = EV_NONE;
            debounce_next = '0;
        end
        else
        begin
            if (state_reg != ST_IDLE && timer_reg != TIMER_MAX)
            begin
                timer_inc = timer_reg + 16'd1;
            end
            timer_next = timer_inc;

            if (sample.raw_level != stable_reg)
            begin
                if (dc_inc >= deb_ticks_reg)
                begin
                    stable_next   = sample.raw_level;
                    debounce_next = '0;
                end
                else
                begin
                    debounce_next = dc_inc;
                end
            end
            else
            begin
                debounce_next = '0;
            end

            down = (stable_next == active_reg);

            case (state_reg)
                ST_IDLE:
                begin
                    if (down)
                    begin
                        timer_next  = '0;
                        repeat_next = 4'd1;
                        state_next  = ST_PRESS;
                        emitted     = 1'b1;
                        emit_ev     = EV_DOWN;
                    end
                    else
                    begin
                        held_next = EV_NONE;
                    end
                end
                ST_PRESS:
                begin
                    if (!down)
                    begin
                        timer_next = '0;
                        state_next = ST_RELEASE;
                        emitted    = 1'b1;
                        emit_ev    = EV_UP;
                    end
                    else if (timer_inc > long_reg)
                    begin
                        state_next = ST_LONG;
                        emitted    = 1'b1;
                        emit_ev    = EV_LSTART;
                    end
                end
                ST_RELEASE:
                begin
                    if (down)
                    begin
                        if (repeat_reg < rmax_reg)
                        begin
                            repeat_next = repeat_reg + 4'd1;
                        end
                        timer_next       = '0;
                        state_next       = ST_REPEAT;
                        emitted          = 1'b1;
                        emit_ev          = EV_REPEAT;
                        push_entry.two   = 1'b1;
                    end
                    else if (timer_inc > short_reg)
                    begin
                        state_next = ST_IDLE;
                        if (repeat_reg == 4'd1)
                        begin
                            emitted = 1'b1;
                            emit_ev = EV_SINGLE;
                        end
                        else if (repeat_reg == 4'd2)
                        begin
                            emitted = 1'b1;
                            emit_ev = EV_DOUBLE;
                        end
                    end
                end
                ST_REPEAT:
                begin
                    if (!down)
                    begin
                        if (timer_inc < short_reg)
                        begin
                            timer_next = '0;
                            state_next = ST_RELEASE;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                        emitted = 1'b1;
                        emit_ev = EV_UP;
                    end
                    else if (timer_inc > short_reg)
                    begin
                        timer_next  = '0;
                        repeat_next = '0;
                        state_next  = ST_PRESS;
                    end
                end
                ST_LONG:
                begin
                    emitted = 1'b1;
                    if (down)
                    begin
                        emit_ev = EV_LHOLD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        emit_ev    = EV_UP;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        if (emitted)
        begin
            held_next = emit_ev;
        end

        push_entry.pressed = (stable_next == active_reg);
        if (push_entry.two)
        begin
            push_entry.ev0  = EV_DOWN;
            push_entry.lat0 = EV_DOWN;
            push_entry.rep0 = repeat_reg;
            push_entry.ev1  = EV_REPEAT;
            push_entry.rep1 = repeat_next;
        end
        else
        begin
            push_entry.ev0  = emit_ev;
            push_entry.lat0 = held_next;
            push_entry.rep0 = repeat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timer_reg     <= '0;
            debounce_reg  <= '0;
            stable_reg    <= 1'b1;
            repeat_reg    <= '0;
            held_reg      <= EV_NONE;
            active_reg    <= 1'b0;
            deb_ticks_reg <= 4'd3;
            short_reg     <= 16'd60;
            long_reg      <= 16'd200;
            rmax_reg      <= 4'd15;
        end
        else
        begin
            if (accept)
            begin
                state_reg    <= state_next;
                timer_reg    <= timer_next;
                debounce_reg <= debounce_next;
                stable_reg   <= stable_next;
                repeat_reg   <= repeat_next;
                held_reg     <= held_next;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_ACTIVE_LEVEL:
                    begin
                        active_reg <= cfg_data[0];
                        stable_reg <= ~cfg_data[0];
                    end
                    CFG_DEBOUNCE_TICKS: deb_ticks_reg <= cfg_data[3:0];
                    CFG_SHORT_TICKS:    short_reg     <= cfg_data;
                    CFG_LONG_TICKS:     long_reg      <= cfg_data;
                    CFG_REPEAT_MAX:     rmax_reg      <= cfg_data[3:0];
                    default:            ;
                endcase
            end
        end
    end

endmodule

// File: rtl/bced_queue.sv
// Short queue of classified samples between the front and back parts.
module bced_queue
#(
    parameter int DEPTH = bced_pkg::BCED_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  bced_pkg::bced_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop,
    output bced_pkg::bced_entry_t pop_entry
);
    import bced_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bced_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/bced_back.sv
// Back part: splits queue entries into results and holds the output register.
module bced_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    input  bced_pkg::bced_entry_t pop_entry,
    output logic                  pop,
    bced_out_if.source            result
);
    import bced_pkg::*;

    logic       valid_reg;
    logic       phase_reg;
    logic [2:0] event_reg;
    logic       last_reg;
    logic [2:0] latched_reg;
    logic [3:0] repeat_reg;
    logic       pressed_reg;
    logic       load;

    assign load = !valid_reg || result.ready;
    assign pop  = load && pop_valid && (phase_reg || !pop_entry.two);

    assign result.valid         = valid_reg;
    assign result.event_res     = event_reg;
    assign result.last          = last_reg;
    assign result.latched_event = latched_reg;
    assign result.repeat_count  = repeat_reg;
    assign result.pressed       = pressed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= pop_valid;
            if (pop_valid && pop_entry.two)
            begin
                phase_reg <= !phase_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && pop_valid)
        begin
            pressed_reg <= pop_entry.pressed;
            if (phase_reg)
            begin
                event_reg   <= pop_entry.ev1;
                latched_reg <= pop_entry.ev1;
                repeat_reg  <= pop_entry.rep1;
                last_reg    <= 1'b1;
            end
            else
            begin
                event_reg   <= pop_entry.ev0;
                latched_reg <= pop_entry.lat0;
                repeat_reg  <= pop_entry.rep0;
                last_reg    <= !pop_entry.two;
            end
        end
    end

endmodule

// File: rtl/button_click_event_detector.sv
// Top level of the button click event detector: front, queue and back parts.
//
//   Channel   Direction  Payload                                               Transaction
//   sample    in         action, raw_level                                     valid & ready
//   result    out        event_res, last, latched_event, repeat_count, pressed valid & ready
//   cfg       in         cfg_index, cfg_data                                   cfg_write_en
//
// The front part takes one sample per cycle while the queue has room; its state update
// finishes in that cycle. A sample yields one or two results, and the back part sends one
// result per cycle, so one sample per cycle is sustained except for a repeated press.
// The front stalls only when the queue is full; the back stalls on result.ready.
// Reset restores the register defaults and clears control state at once, not queue or result data.
module button_click_event_detector
#(
    parameter int QUEUE_DEPTH = bced_pkg::BCED_QUEUE_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    bced_in_if.sink                          sample,
    bced_out_if.source                       result,
    input  logic                             cfg_write_en,
    input  logic [bced_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bced_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bced_pkg::*;

    logic        push_valid;
    logic        push_ready;
    bced_entry_t push_entry;
    logic        pop_valid;
    logic        pop;
    bced_entry_t pop_entry;

    bced_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push_ready   (push_ready),
        .push_valid   (push_valid),
        .push_entry   (push_entry)
    );

    bced_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    bced_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop       (pop),
        .result    (result)
    );

    // The front is only held off while the queue has entries waiting.
    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> pop_valid)
        else $error("sample stalled with an empty queue");

    // A repeat event always closes its transaction group.
    a_repeat_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.event_res == EV_REPEAT |-> result.last)
        else $error("repeat event not marked last");

    // Only a press down can open a two-result group.
    a_first_is_down: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.last |-> result.event_res == EV_DOWN)
        else $error("non-final result is not a press down");

    // The second result of a group follows right after the first one is taken.
    a_repeat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !result.last
        |=> result.valid && result.event_res == EV_REPEAT)
        else $error("press down not followed by repeat");

endmodule
